// ===== src/fasta_fastq_kmer_extractor_unit_assert.svh =====
// Assertion macros for the checker file of the k-mer extractor.
`ifndef FASTA_FASTQ_KMER_EXTRACTOR_UNIT_ASSERT_SVH
`define FASTA_FASTQ_KMER_EXTRACTOR_UNIT_ASSERT_SVH

// Check a property on every rising edge of clk, skipped while rst is high.
`define FQK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge of clk, reset cycles included.
`define FQK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/fqk_pkg.sv =====
// Shared types, byte codes and classification functions of the k-mer extractor.
`default_nettype none

package fqk_pkg;

  localparam int K_W      = 6;   // width of K and of the valid-base count
  localparam int CODE_W   = 64;  // width of the kmer_code field
  localparam int OUT_ID_W = 40;  // width of the ID fields

  localparam logic [7:0] CH_HEADER_FA = 8'h3E;  // '>'
  localparam logic [7:0] CH_HEADER_FQ = 8'h40;  // '@'
  localparam logic [7:0] CH_PLUS      = 8'h2B;  // '+'
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;  // '\n'
  localparam logic [7:0] CH_SPACE     = 8'h20;  // ' '
  localparam logic [7:0] CH_QUAL_LAST = 8'h7F;

  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_FA_HDR  = 3'd1;
  localparam logic [2:0] MODE_FA_SEQ  = 3'd2;
  localparam logic [2:0] MODE_FQ_HDR  = 3'd3;
  localparam logic [2:0] MODE_FQ_SEQ  = 3'd4;
  localparam logic [2:0] MODE_FQ_PLUS = 3'd5;
  localparam logic [2:0] MODE_FQ_QUAL = 3'd6;

  // What the parser tells the window for one byte.
  typedef struct packed {
    logic clear;   // start of file: drop all stream state first
    logic hdr;     // new record header
    logic seq;     // byte belongs to a sequence line
  } act_t;

  typedef struct packed {
    logic       is_base;
    logic [1:0] code;
  } base_t;

  typedef struct packed {
    logic [CODE_W-1:0]   kmer_code;
    logic [OUT_ID_W-1:0] absolute_id;
    logic [OUT_ID_W-1:0] relative_id;
  } result_t;

  function automatic base_t base_code(input logic [7:0] c);
    base_t b;
    b = '{is_base: 1'b1, code: 2'd0};
    case (c) inside
      8'h41, 8'h61: b.code = 2'd0;
      8'h43, 8'h63: b.code = 2'd1;
      8'h47, 8'h67: b.code = 2'd2;
      8'h54, 8'h74: b.code = 2'd3;
      default:      b.is_base = 1'b0;
    endcase
    return b;
  endfunction

  // IUPAC degeneracy letters R Y S W K M B D H V N in either case.
  function automatic logic is_degenerate(input logic [7:0] c);
    logic [7:0] lc;
    logic       d;
    lc = c | CH_SPACE;
    case (lc) inside
      8'h72, 8'h79, 8'h73, 8'h77, 8'h6B, 8'h6D,
      8'h62, 8'h64, 8'h68, 8'h76, 8'h6E: d = 1'b1;
      default:                          d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/fqk_ifs.sv =====
// Handshake channel interfaces: input bytes, output k-mers, configuration writes.
`default_nettype none

interface fqk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, data_byte, start_of_file, input ready);
  modport sink (input valid, data_byte, start_of_file, output ready);
endinterface

interface fqk_kmer_if;
  logic        valid;
  logic        ready;
  logic [63:0] kmer_code;
  logic [39:0] absolute_id;
  logic [39:0] relative_id;

  modport source (output valid, kmer_code, absolute_id, relative_id, input ready);
  modport sink (input valid, kmer_code, absolute_id, relative_id, output ready);
endinterface

interface fqk_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] k_size;

  modport source (output valid, k_size, input ready);
  modport sink (input valid, k_size, output ready);
endinterface

`default_nettype wire

// ===== src/fqk_parser.sv =====
// Record format parser: line tracking, parse mode and FASTQ quality countdown.
`default_nettype none

module fqk_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   advance,
  input  wire logic                   clear,
  input  wire logic [7:0]             c,
  input  wire logic [LENGTH_BITS-1:0] position,
  output fqk_pkg::act_t               act
);

  logic [2:0]             mode;
  logic [2:0]             mode_next;
  logic                   at_line_start;
  logic                   at_line_start_next;
  logic [LENGTH_BITS-1:0] quality;
  logic [LENGTH_BITS-1:0] quality_next;

  logic [2:0]             mode_cur;
  logic                   line;
  logic [LENGTH_BITS-1:0] quality_cur;
  logic                   is_qual_byte;

  always_comb begin
    mode_cur           = clear ? fqk_pkg::MODE_NONE : mode;
    line               = clear | at_line_start;
    quality_cur        = clear ? '0 : quality;
    is_qual_byte       = (c > fqk_pkg::CH_SPACE) && (c <= fqk_pkg::CH_QUAL_LAST);
    mode_next          = mode_cur;
    at_line_start_next = (c == fqk_pkg::CH_NEWLINE);
    quality_next       = quality_cur;
    act.clear          = clear;
    act.hdr            = 1'b0;
    act.seq            = 1'b0;
    case (mode_cur)
      fqk_pkg::MODE_NONE: begin
        if (line && c == fqk_pkg::CH_HEADER_FA) begin
          act.hdr   = 1'b1;
          mode_next = fqk_pkg::MODE_FA_HDR;
        end else if (line && c == fqk_pkg::CH_HEADER_FQ) begin
          act.hdr   = 1'b1;
          mode_next = fqk_pkg::MODE_FQ_HDR;
        end
        // a file that opens with anything else stays rejected
        at_line_start_next = 1'b0;
      end
      fqk_pkg::MODE_FA_HDR: begin
        if (c == fqk_pkg::CH_NEWLINE) mode_next = fqk_pkg::MODE_FA_SEQ;
      end
      fqk_pkg::MODE_FA_SEQ: begin
        if (line && c == fqk_pkg::CH_HEADER_FA) begin
          act.hdr   = 1'b1;
          mode_next = fqk_pkg::MODE_FA_HDR;
        end else begin
          act.seq = 1'b1;
        end
      end
      fqk_pkg::MODE_FQ_HDR: begin
        if (c == fqk_pkg::CH_NEWLINE) mode_next = fqk_pkg::MODE_FQ_SEQ;
      end
      fqk_pkg::MODE_FQ_SEQ: begin
        if (line && c == fqk_pkg::CH_PLUS) begin
          quality_next = position;
          mode_next    = fqk_pkg::MODE_FQ_PLUS;
        end else begin
          act.seq = 1'b1;
        end
      end
      fqk_pkg::MODE_FQ_PLUS: begin
        if (c == fqk_pkg::CH_NEWLINE) mode_next = fqk_pkg::MODE_FQ_QUAL;
      end
      fqk_pkg::MODE_FQ_QUAL: begin
        if (line && c == fqk_pkg::CH_HEADER_FQ && quality_cur == '0) begin
          act.hdr   = 1'b1;
          mode_next = fqk_pkg::MODE_FQ_HDR;
        end else if (is_qual_byte && quality_cur != '0) begin
          quality_next = quality_cur - 1'b1;
        end
      end
      default: begin
        mode_next = mode_cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= fqk_pkg::MODE_NONE;
      at_line_start <= 1'b1;
      quality       <= '0;
    end else if (advance) begin
      mode          <= mode_next;
      at_line_start <= at_line_start_next;
      quality       <= quality_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/fqk_window.sv =====
// Base window, position and k-mer counters; forms the result for one byte.
`default_nettype none

module fqk_window #(
  parameter int MAX_K       = 32,
  parameter int ID_BITS     = 40,
  parameter int LENGTH_BITS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      advance,
  input  wire fqk_pkg::act_t             act,
  input  wire logic [7:0]                c,
  input  wire logic [fqk_pkg::K_W-1:0]   k_eff,
  input  wire logic [fqk_pkg::K_W-1:0]   k_m1,
  output logic [LENGTH_BITS-1:0]         position,
  output logic                           emit,
  output fqk_pkg::result_t               result
);

  localparam int W = 2 * MAX_K;

  logic [W-1:0]              window;
  logic [W-1:0]              window_next;
  logic [fqk_pkg::K_W-1:0]   valid_bases;
  logic [fqk_pkg::K_W-1:0]   valid_bases_next;
  logic [LENGTH_BITS-1:0]    position_next;
  logic [ID_BITS-1:0]        counter;
  logic [ID_BITS-1:0]        counter_next;
  logic [ID_BITS-1:0]        rel_count;     // counter minus its value at record start
  logic [ID_BITS-1:0]        rel_count_next;

  logic [W-1:0]              window_cur;
  logic [fqk_pkg::K_W-1:0]   valid_cur;
  logic [LENGTH_BITS-1:0]    pos_cur;
  logic [ID_BITS-1:0]        counter_cur;
  logic [ID_BITS-1:0]        rel_cur;
  fqk_pkg::base_t            b;
  logic                      degen;
  logic                      step;
  logic                      count_up;
  logic [W-1:0]              mask;
  logic [63:0]               abs_wide;
  logic [63:0]               rel_wide;

  always_comb begin
    window_cur  = act.clear ? '0 : window;
    valid_cur   = act.clear ? '0 : valid_bases;
    pos_cur     = act.clear ? '0 : position;
    counter_cur = act.clear ? '0 : counter;
    rel_cur     = act.clear ? '0 : rel_count;
    b           = fqk_pkg::base_code(c);
    degen       = fqk_pkg::is_degenerate(c);
    step        = act.seq && (b.is_base || degen);
    // the new position reaches K exactly when the old one was at least K-1
    count_up    = step && (pos_cur >= LENGTH_BITS'(k_m1)) && (counter_cur != '1);

    window_next      = window_cur;
    valid_bases_next = valid_cur;
    position_next    = pos_cur;
    counter_next     = counter_cur;
    rel_count_next   = rel_cur;
    emit             = 1'b0;

    if (act.hdr) begin
      window_next      = '0;
      valid_bases_next = '0;
      position_next    = '0;
      rel_count_next   = '0;
    end else if (step) begin
      if (pos_cur != '1) position_next = pos_cur + 1'b1;
      if (count_up) begin
        counter_next   = counter_cur + 1'b1;
        rel_count_next = rel_cur + 1'b1;
      end
      if (b.is_base) begin
        window_next      = (window_cur << 2) | W'(b.code);
        valid_bases_next = (valid_cur >= k_m1) ? k_eff : valid_cur + 1'b1;
        emit             = (valid_cur >= k_m1);
      end else begin
        window_next      = '0;
        valid_bases_next = '0;
      end
    end

    for (int i = 0; i < MAX_K; i++) begin
      mask[2*i +: 2] = {2{fqk_pkg::K_W'(i) < k_eff}};
    end
    abs_wide           = 64'(counter_next);
    rel_wide           = 64'(rel_count_next);
    result.kmer_code   = fqk_pkg::CODE_W'(window_next & mask);
    result.absolute_id = abs_wide[fqk_pkg::OUT_ID_W-1:0];
    result.relative_id = rel_wide[fqk_pkg::OUT_ID_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window      <= '0;
      valid_bases <= '0;
      position    <= '0;
      counter     <= '0;
      rel_count   <= '0;
    end else if (advance) begin
      window      <= window_next;
      valid_bases <= valid_bases_next;
      position    <= position_next;
      counter     <= counter_next;
      rel_count   <= rel_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/fasta_fastq_kmer_extractor_unit.sv =====
// FASTA/FASTQ k-mer extractor top level: input stage, parser, window, result register.
//
// Takes one file byte per beat on bytes and returns each complete window of K bases on
// kmers with its file-wide and record-relative IDs. Throughput is one byte per clock
// while kmers is not stalled; a result reaches kmers through the input register, then
// the single-pass update of parse state, window and counters into the result register.
// The input register also holds one byte while a result waits on kmers, so the byte
// stream takes one more byte while the output stalls. K comes from the k_size register
// (reset value 31, zero acts as 1, values above MAX_K act as MAX_K); write it on cfg
// only while no byte is in flight. start_of_file on a byte clears all stream state before
// that byte is parsed.
`default_nettype none

module fasta_fastq_kmer_extractor_unit #(
  parameter int MAX_K       = 32,
  parameter int ID_BITS     = 40,
  parameter int LENGTH_BITS = 32
) (
  input wire logic  clk,
  input wire logic  rst,
  fqk_byte_if.sink  bytes,
  fqk_kmer_if.source kmers,
  fqk_cfg_if.sink   cfg
);

  logic                        a_valid;
  logic [7:0]                  a_byte;
  logic                        a_sof;
  logic                        advance;
  logic [fqk_pkg::K_W-1:0]     k_size;
  logic [fqk_pkg::K_W-1:0]     k_eff;
  logic [fqk_pkg::K_W-1:0]     k_m1;
  fqk_pkg::act_t               act;
  logic [LENGTH_BITS-1:0]      position;
  logic                        emit;
  fqk_pkg::result_t            result;
  logic                        out_valid;
  fqk_pkg::result_t            out_data;
  logic                        out_room;

  assign out_room    = !out_valid || kmers.ready;
  assign advance     = a_valid && out_room;
  assign bytes.ready = !a_valid || out_room;
  assign cfg.ready   = 1'b1;

  always_comb begin
    if (k_size == '0) begin
      k_eff = fqk_pkg::K_W'(1);
    end else if (k_size > fqk_pkg::K_W'(MAX_K)) begin
      k_eff = fqk_pkg::K_W'(MAX_K);
    end else begin
      k_eff = k_size;
    end
    k_m1 = k_eff - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_size <= fqk_pkg::K_W'(31);
    end else if (cfg.valid) begin
      k_size <= cfg.k_size;
    end
  end

  // input stage: hold the byte until the result register has room
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      a_byte <= bytes.data_byte;
      a_sof  <= bytes.start_of_file;
    end
  end

  fqk_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .clear    (a_sof),
    .c        (a_byte),
    .position (position),
    .act      (act)
  );

  fqk_window #(
    .MAX_K       (MAX_K),
    .ID_BITS     (ID_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .act      (act),
    .c        (a_byte),
    .k_eff    (k_eff),
    .k_m1     (k_m1),
    .position (position),
    .emit     (emit),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (kmers.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) out_data <= result;
  end

  assign kmers.valid       = out_valid;
  assign kmers.kmer_code   = out_data.kmer_code;
  assign kmers.absolute_id = out_data.absolute_id;
  assign kmers.relative_id = out_data.relative_id;

endmodule

`default_nettype wire

// ===== src/fqk_checker.sv =====
// Port-level assertions for the k-mer extractor and their bind to the top level.
`default_nettype none
`include "fasta_fastq_kmer_extractor_unit_assert.svh"

module fqk_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] kmer_code,
  input wire logic [39:0] absolute_id,
  input wire logic [39:0] relative_id
);

  logic         stalled;
  logic [143:0] out_fields;

  assign stalled    = out_valid && !out_ready;
  assign out_fields = {kmer_code, absolute_id, relative_id};

  `FQK_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid, "result valid after reset")
  `FQK_ASSERT(a_hold_on_stall, stalled |=> $stable(out_fields), "result changed in stall")
  `FQK_ASSERT(a_no_input_stall, out_ready |-> in_ready, "input stalled while output drains")
  `FQK_ASSERT(a_ids_start_at_one, out_valid |-> |absolute_id && |relative_id, "k-mer ID of zero")

endmodule

bind fasta_fastq_kmer_extractor_unit fqk_checker u_fqk_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (bytes.ready),
  .out_valid   (kmers.valid),
  .out_ready   (kmers.ready),
  .kmer_code   (kmers.kmer_code),
  .absolute_id (kmers.absolute_id),
  .relative_id (kmers.relative_id)
);

`default_nettype wire
